@@ rtl/dahdr_envelope_generator_top_defines.svh @@
// Assertion macros for the envelope generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DAHDR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`define DAHDR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define DAHDR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define DAHDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DAHDR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DAHDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/dahdr_pkg.sv @@
// Package for the envelope generator: field widths, phase and mode codes,
// timing, divider control and sequencer state types. Depends on nothing.
`timescale 1ns / 1ps
package dahdr_pkg;

   localparam int LEN_W       = 16;
   localparam int LEVEL_OUT_W = 17;
   localparam int PHASE_W     = 3;
   localparam int MODE_W      = 2;

   localparam int COUNT_BITS_DEF      = 16;
   localparam int LEVEL_FRAC_BITS_DEF = 16;

   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DELAY   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd5;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd6;

   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0] dly_len;
      logic [LEN_W-1:0] atk_len;
      logic [LEN_W-1:0] hld_len;
      logic [LEN_W-1:0] dcy_len;
      logic [LEN_W-1:0] rel_len;
      logic             solid;
   } timing_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] rem_init;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_RESP = 3'b100
   } seq_state_type;

endpackage

@@ rtl/dahdr_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on dahdr_pkg for field widths.
`timescale 1ns / 1ps
interface dahdr_req_if;
   import dahdr_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [LEN_W-1:0]    delay_len;
   logic [LEN_W-1:0]    attack_len;
   logic [LEN_W-1:0]    hold_len;
   logic [LEN_W-1:0]    decay_len;
   logic [LEN_W-1:0]    release_len;
   logic                solid;

   modport source (
      output valid, mode, delay_len, attack_len, hold_len, decay_len, release_len, solid,
      input  ready
   );
   modport sink (
      input  valid, mode, delay_len, attack_len, hold_len, decay_len, release_len, solid,
      output ready
   );
endinterface

interface dahdr_rsp_if;
   import dahdr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LEVEL_OUT_W-1:0] level;
   logic [PHASE_W-1:0]     phase;
   logic                   note_queued;

   modport source (
      output valid, level, phase, note_queued,
      input  ready
   );
   modport sink (
      input  valid, level, phase, note_queued,
      output ready
   );
endinterface

@@ rtl/dahdr_div.sv @@
// Shared restoring divider, one quotient bit per cycle. The starting
// remainder must be below the divisor. Depends on dahdr_pkg.
`timescale 1ns / 1ps
module dahdr_div #(
   parameter int QUOT_BITS = dahdr_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dahdr_pkg::div_req_type div_req,
   output dahdr_pkg::div_rsp_type div_rsp,
   output logic [QUOT_BITS-1:0]   quot
);
   import dahdr_pkg::*;

   localparam int ITER_W = $clog2(QUOT_BITS + 1);

   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     div_ff, div_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [LEN_W:0] shifted;
   logic [LEN_W:0] diff;
   logic           fits;

   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         div_in  = div_req.divisor;
         quot_in = '0;
         iter_in = ITER_W'(QUOT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign quot         = quot_ff;

endmodule

@@ rtl/dahdr_envelope_generator_top.sv @@
// Envelope generator top level: delay, attack, hold, decay, sustain, release.
// A tick in attack, decay or release runs the shared divider; its response is
// valid once the divider has reported done. Other beats respond in the cycle
// after acceptance. One beat is in flight at a time: a new beat is taken only
// after the response to the last one has been taken.
// Synchronous active-high reset clears all envelope state to idle and zero.
`timescale 1ns / 1ps
`include "dahdr_envelope_generator_top_defines.svh"
module dahdr_envelope_generator_top #(
   parameter int COUNT_BITS      = dahdr_pkg::COUNT_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = dahdr_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dahdr_req_if.sink  req_bus,
   dahdr_rsp_if.source rsp_bus
);
   import dahdr_pkg::*;

   // Level is unsigned fixed point with one integer bit; ONE is full scale.
   localparam int LEVEL_W   = LEVEL_FRAC_BITS + 1;
   localparam int CMP_W     = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
   localparam int OUT_EXT_W = (LEVEL_W > LEVEL_OUT_W) ? LEVEL_W : LEVEL_OUT_W;
   localparam logic [LEVEL_W-1:0]    ONE       = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Sequencer and envelope state.
   seq_state_type           state_ff, state_in;
   logic [PHASE_W-1:0]      cur_phase_ff, phase_in;
   logic [LEVEL_W-1:0]      env_level_ff, level_in;
   logic [COUNT_BITS-1:0]   phase_count_ff, count_in;
   timing_type              act_ff, act_in;
   timing_type              pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;

   // Response holding register.
   logic [LEVEL_OUT_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [PHASE_W-1:0]      rsp_phase_ff;
   logic                    rsp_queued_ff;
   logic                    load_rsp;

   // Shared divider.
   div_req_type                div_req;
   div_rsp_type                div_rsp;
   logic [LEVEL_FRAC_BITS-1:0] quot;

   logic                  req_fire;
   logic                  rsp_fire;
   timing_type            req_timing;
   logic [COUNT_BITS-1:0] cnt_up;
   logic [CMP_W-1:0]      cnt_up_ext;
   logic [CMP_W-1:0]      cnt_ff_ext;
   logic [LEVEL_W-1:0]    rel_step;
   logic [LEVEL_W-1:0]    rel_level;
   logic                  idle_like;

   // Arm request: load a timing into the active set and restart the cycle.
   logic                  do_arm;
   logic                  arm_keep_level;
   timing_type            arm_src;

   // Ticks in delay, hold, sustain and idle report a fixed level rather
   // than the stored one.
   logic                  out_fixed;
   logic [LEVEL_W-1:0]    out_fixed_val;
   logic [LEVEL_W-1:0]    out_level;
   logic [OUT_EXT_W-1:0]  out_level_ext;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   assign req_timing = '{
      dly_len: req_bus.delay_len,
      atk_len: req_bus.attack_len,
      hld_len: req_bus.hold_len,
      dcy_len: req_bus.decay_len,
      rel_len: req_bus.release_len,
      solid:   req_bus.solid
   };

   // The sample counter saturates rather than wrapping.
   assign cnt_up     = (phase_count_ff == COUNT_MAX) ? phase_count_ff
                                                     : phase_count_ff + COUNT_BITS'(1);
   assign cnt_up_ext = CMP_W'(cnt_up);
   assign cnt_ff_ext = CMP_W'(phase_count_ff);

   // Release step is ONE / release_len, at least one LSB, and full scale for
   // lengths of zero or one (the divider handles only lengths of two or more).
   assign rel_step  = (act_ff.rel_len < LEN_W'(2)) ? ONE
                    : (quot == '0) ? LEVEL_W'(1) : LEVEL_W'(quot);
   assign rel_level = (env_level_ff > rel_step) ? env_level_ff - rel_step : '0;

   // A phase code above release cannot occur; it is handled as idle.
   assign idle_like = (cur_phase_ff == PH_IDLE) || (cur_phase_ff > PH_RELEASE);

   always_comb begin
      state_in       = state_ff;
      phase_in       = cur_phase_ff;
      level_in       = env_level_ff;
      count_in       = phase_count_ff;
      act_in         = act_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      do_arm         = 1'b0;
      arm_keep_level = 1'b0;
      arm_src        = req_timing;
      out_fixed      = 1'b0;
      out_fixed_val  = '0;
      div_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_RESP;
               if (req_bus.mode == MODE_TICK) begin
                  case (cur_phase_ff)
                     PH_DELAY: begin
                        count_in  = cnt_up;
                        out_fixed = 1'b1;
                        if (cnt_up_ext >= CMP_W'(act_ff.dly_len)) begin
                           phase_in = PH_ATTACK;
                           count_in = '0;
                        end
                     end
                     PH_ATTACK: begin
                        // Ramp up: count * ONE / attack_len.
                        count_in         = cnt_up;
                        div_req.start    = 1'b1;
                        div_req.rem_init = cnt_up_ext[LEN_W-1:0];
                        div_req.divisor  = act_ff.atk_len;
                        state_in         = S_CALC;
                     end
                     PH_DECAY: begin
                        count_in         = cnt_up;
                        div_req.start    = 1'b1;
                        div_req.rem_init = cnt_up_ext[LEN_W-1:0];
                        div_req.divisor  = act_ff.dcy_len;
                        state_in         = S_CALC;
                     end
                     PH_RELEASE: begin
                        // Step size: ONE / release_len.
                        count_in         = cnt_up;
                        div_req.start    = 1'b1;
                        div_req.rem_init = LEN_W'(1);
                        div_req.divisor  = act_ff.rel_len;
                        state_in         = S_CALC;
                     end
                     PH_HOLD: begin
                        count_in      = cnt_up;
                        out_fixed     = 1'b1;
                        out_fixed_val = ONE;
                        if (cnt_up_ext >= CMP_W'(act_ff.hld_len)) begin
                           phase_in = act_ff.solid ? PH_SUSTAIN : PH_DECAY;
                           count_in = '0;
                        end
                     end
                     PH_SUSTAIN: begin
                        out_fixed     = 1'b1;
                        out_fixed_val = ONE;
                     end
                     default: begin
                        phase_in  = PH_IDLE;
                        out_fixed = 1'b1;
                     end
                  endcase
               end else if (req_bus.mode == MODE_NOTE_ON) begin
                  if (idle_like || cur_phase_ff == PH_RELEASE) begin
                     // Arm at once; from release the ramp starts at the
                     // current level.
                     do_arm         = 1'b1;
                     arm_keep_level = (cur_phase_ff == PH_RELEASE);
                  end else begin
                     // Queue the timing (latest wins); sustain releases now.
                     pend_in       = req_timing;
                     pend_valid_in = 1'b1;
                     if (cur_phase_ff == PH_SUSTAIN) begin
                        phase_in = PH_RELEASE;
                        count_in = '0;
                     end
                  end
               end else if (req_bus.mode == MODE_NOTE_OFF) begin
                  if (idle_like) begin
                     phase_in = PH_IDLE;
                  end else if (cur_phase_ff != PH_RELEASE) begin
                     phase_in = PH_RELEASE;
                     count_in = '0;
                  end
               end else begin
                  // Unused mode code leaves the envelope alone.
                  if (idle_like) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         S_CALC: begin
            if (div_rsp.done) begin
               state_in = S_RESP;
               case (cur_phase_ff)
                  PH_ATTACK: begin
                     if (cnt_ff_ext >= CMP_W'(act_ff.atk_len)) begin
                        level_in = ONE;
                        count_in = '0;
                        if (act_ff.hld_len != '0) begin
                           phase_in = PH_HOLD;
                        end else begin
                           phase_in = act_ff.solid ? PH_SUSTAIN : PH_DECAY;
                        end
                     end else begin
                        level_in = LEVEL_W'(quot);
                     end
                  end
                  PH_DECAY: begin
                     if (cnt_ff_ext >= CMP_W'(act_ff.dcy_len)) begin
                        // End of a pulse: take a queued note, or loop.
                        level_in = '0;
                        if (pend_valid_ff) begin
                           do_arm  = 1'b1;
                           arm_src = pend_ff;
                        end else begin
                           count_in = '0;
                           phase_in = (act_ff.dly_len != '0) ? PH_DELAY : PH_ATTACK;
                        end
                     end else begin
                        level_in = ONE - LEVEL_W'(quot);
                     end
                  end
                  PH_RELEASE: begin
                     level_in = rel_level;
                     if (rel_level == '0) begin
                        phase_in = PH_IDLE;
                        count_in = '0;
                        if (pend_valid_ff) begin
                           do_arm  = 1'b1;
                           arm_src = pend_ff;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         S_RESP: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_arm) begin
         act_in        = arm_src;
         count_in      = '0;
         pend_valid_in = 1'b0;
         phase_in      = (arm_src.dly_len != '0) ? PH_DELAY : PH_ATTACK;
         if (!arm_keep_level) begin
            level_in = '0;
         end
      end
   end

   assign out_level     = out_fixed ? out_fixed_val : level_in;
   assign out_level_ext = OUT_EXT_W'(out_level);
   assign rsp_level_in  = out_level_ext[LEVEL_OUT_W-1:0];
   assign load_rsp      = (state_in == S_RESP) && (state_ff != S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cur_phase_ff   <= PH_IDLE;
         env_level_ff   <= '0;
         phase_count_ff <= '0;
         act_ff         <= '0;
         pend_ff        <= '0;
         pend_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_phase_ff   <= phase_in;
         env_level_ff   <= level_in;
         phase_count_ff <= count_in;
         act_ff         <= act_in;
         pend_ff        <= pend_in;
         pend_valid_ff  <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_level_ff  <= rsp_level_in;
         rsp_phase_ff  <= phase_in;
         rsp_queued_ff <= pend_valid_in;
      end
   end

   dahdr_div #(
      .QUOT_BITS (LEVEL_FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .quot    (quot)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = (state_ff == S_RESP);
   assign rsp_bus.level       = rsp_level_ff;
   assign rsp_bus.phase       = rsp_phase_ff;
   assign rsp_bus.note_queued = rsp_queued_ff;

   // A divider result only arrives while the sequencer waits for it.
   `DAHDR_ASSERT_SAME(a_done_in_calc, clock, reset, div_rsp.done, state_ff == S_CALC, "divider done outside calc")
   // Entering calc always launches the divider.
   `DAHDR_ASSERT_NEXT(a_calc_starts_div, clock, reset, req_fire && state_in == S_CALC, div_rsp.busy, "divider not started")
   // The stored level never exceeds full scale.
   `DAHDR_ASSERT_SAME(a_level_range, clock, reset, 1'b1, env_level_ff <= ONE, "level above full scale")
   // Hold and sustain always sit at full scale.
   `DAHDR_ASSERT_SAME(a_full_in_hold, clock, reset, cur_phase_ff == PH_HOLD || cur_phase_ff == PH_SUSTAIN, env_level_ff == ONE, "hold or sustain below full scale")
   // A taken response frees the block for the next beat.
   `DAHDR_ASSERT_NEXT(a_ready_after_rsp, clock, reset, rsp_fire, req_bus.ready, "not ready after response")

endmodule

@@ tb/tb_dahdr_envelope_generator_top.sv @@
// Self-checking testbench for the envelope generator top level.
// Depends on dahdr_pkg, dahdr_if (dahdr_req_if, dahdr_rsp_if) and dahdr_envelope_generator_top from the RTL.
`timescale 1ns / 1ps
module tb_dahdr_envelope_generator_top;
   import dahdr_pkg::*;

   // Mode code 3 has no function; the block must report the current level and
   // leave its state alone.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int FRAC = LEVEL_FRAC_BITS_DEF;
   localparam logic [LEVEL_OUT_W-1:0] FULL_LEVEL = LEVEL_OUT_W'(1) << FRAC;
   localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

   // Once nothing is owed, a further drain is plenty to catch any stray response.
   localparam int DRAIN_CYCLES   = 4 * (LEVEL_FRAC_BITS_DEF + 3);
   localparam int RX_HOLD_CYCLES = 300;
   // The timeout leaves ample margin over the slowest correct run.
   localparam int TIMEOUT_NS     = 4_000_000;
   localparam int MAX_PRINTED    = 100;

   typedef struct packed {
      logic [LEVEL_OUT_W-1:0] level;
      logic [PHASE_W-1:0]     phase;
      logic                   note_queued;
   } env_result_type;

   localparam timing_type ZERO_TIMING = '0;

   logic clock = 1'b0;
   logic reset;

   dahdr_req_if req_bus ();
   dahdr_rsp_if rsp_bus ();

   dahdr_envelope_generator_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Envelope predictor. This is the block's state as it should be after
   // every accepted request beat; it starts in the reset state.
   // ---------------------------------------------------------------------
   logic [PHASE_W-1:0]        env_phase     = PH_IDLE;
   logic [LEVEL_OUT_W-1:0]    env_level     = '0;
   logic [COUNT_BITS_DEF-1:0] phase_count   = '0;
   timing_type                active_timing = '0;
   timing_type                queued_timing = '0;
   logic                      queued_valid  = 1'b0;

   // Responses still owed by the block, oldest first.
   env_result_type expected_env[$];

   int error_count    = 0;
   int beats_sent     = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   logic rx_hold      = 1'b0;
   event rx_hold_start;

   function automatic void enter_phase(input logic [PHASE_W-1:0] ph);
      env_phase   = ph;
      phase_count = '0;
   endfunction

   // The sample counter saturates rather than wrapping.
   function automatic void bump_count();
      if (phase_count != COUNT_TOP)
         phase_count = phase_count + 1'b1;
   endfunction

   // Arming from release keeps the current level so that the new attack
   // starts from where the release had got to.
   function automatic void arm_timing(input timing_type t);
      active_timing = t;
      if (env_phase != PH_RELEASE)
         env_level = '0;
      enter_phase(t.dly_len != 0 ? PH_DELAY : PH_ATTACK);
      queued_valid = 1'b0;
   endfunction

   // A queued note starts as if from idle, i.e. from level zero.
   function automatic void arm_queued();
      queued_valid = 1'b0;
      enter_phase(PH_IDLE);
      arm_timing(queued_timing);
   endfunction

   // One sample tick; returns the level reported for that tick.
   function automatic logic [LEVEL_OUT_W-1:0] advance_sample();
      logic [47:0]            ratio;
      logic [LEVEL_OUT_W-1:0] step;
      case (env_phase)
         PH_DELAY: begin
            bump_count();
            if (phase_count >= active_timing.dly_len)
               enter_phase(PH_ATTACK);
            return '0;
         end
         PH_ATTACK: begin
            bump_count();
            if (active_timing.atk_len != 0) begin
               ratio = 48'(phase_count);
               ratio = (ratio << FRAC) / active_timing.atk_len;
               env_level = (ratio > FULL_LEVEL) ? FULL_LEVEL : ratio[LEVEL_OUT_W-1:0];
            end else begin
               env_level = FULL_LEVEL;
            end
            if (phase_count >= active_timing.atk_len) begin
               env_level = FULL_LEVEL;
               if (active_timing.hld_len != 0)
                  enter_phase(PH_HOLD);
               else
                  enter_phase(active_timing.solid ? PH_SUSTAIN : PH_DECAY);
            end
            return env_level;
         end
         PH_HOLD: begin
            bump_count();
            if (phase_count >= active_timing.hld_len)
               enter_phase(active_timing.solid ? PH_SUSTAIN : PH_DECAY);
            return FULL_LEVEL;
         end
         PH_DECAY: begin
            bump_count();
            if (active_timing.dcy_len != 0) begin
               ratio = 48'(phase_count);
               ratio = (ratio << FRAC) / active_timing.dcy_len;
               env_level = (ratio >= FULL_LEVEL) ? '0 : FULL_LEVEL - ratio[LEVEL_OUT_W-1:0];
            end else begin
               env_level = '0;
            end
            // End of decay: a queued note takes over, otherwise a pulsed note loops
            // back to its delay, or to its attack when the delay is zero.
            if (phase_count >= active_timing.dcy_len) begin
               env_level = '0;
               if (queued_valid)
                  arm_queued();
               else
                  enter_phase(active_timing.dly_len != 0 ? PH_DELAY : PH_ATTACK);
            end
            return env_level;
         end
         PH_SUSTAIN:
            return FULL_LEVEL;
         PH_RELEASE: begin
            step = (active_timing.rel_len != 0) ? FULL_LEVEL / active_timing.rel_len
                                                : FULL_LEVEL;
            if (step == 0)
               step = 1;
            env_level = (env_level > step) ? env_level - step : '0;
            bump_count();
            if (env_level == 0) begin
               enter_phase(PH_IDLE);
               if (queued_valid)
                  arm_queued();
            end
            return env_level;
         end
         default:
            return '0;
      endcase
   endfunction

   // Applies one accepted request beat and returns the response it must cause.
   function automatic env_result_type step_envelope(input logic [MODE_W-1:0] mode,
                                                    input timing_type t);
      env_result_type r;
      if (mode == MODE_TICK) begin
         r.level = advance_sample();
      end else begin
         if (mode == MODE_NOTE_ON) begin
            if (env_phase == PH_IDLE || env_phase == PH_RELEASE) begin
               arm_timing(t);
            end else begin
               // Latest note wins; a note in sustain also forces a release.
               queued_timing = t;
               queued_valid  = 1'b1;
               if (env_phase == PH_SUSTAIN)
                  enter_phase(PH_RELEASE);
            end
         end else if (mode == MODE_NOTE_OFF) begin
            if (env_phase != PH_IDLE && env_phase != PH_RELEASE)
               enter_phase(PH_RELEASE);
         end
         r.level = env_level;
      end
      r.phase       = env_phase;
      r.note_queued = queued_valid;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   function automatic timing_type make_timing(input logic [LEN_W-1:0] d, a, h, dc, r,
                                              input logic s);
      timing_type t;
      t.dly_len = d;
      t.atk_len = a;
      t.hld_len = h;
      t.dcy_len = dc;
      t.rel_len = r;
      t.solid   = s;
      return t;
   endfunction

   // Mostly short phases so that notes run through all their phases within a
   // few dozen ticks; now and then a full-range or maximum length.
   function automatic logic [LEN_W-1:0] random_length();
      case ($urandom_range(0, 31))
         0:       return '1;
         1:       return LEN_W'($urandom_range(0, 65535));
         default: return LEN_W'($urandom_range(0, 6));
      endcase
   endfunction

   function automatic timing_type random_timing();
      return make_timing(random_length(), random_length(), random_length(),
                         random_length(), random_length(), 1'($urandom_range(0, 1)));
   endfunction

   // Any bit pattern at all, used as payload where the block must ignore it
   // and for noise beats.
   function automatic timing_type random_fields();
      return make_timing(LEN_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 65535)),
                         LEN_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 65535)),
                         LEN_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED)
         $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Sends one request beat. Inputs change only on the falling edge; valid is
   // assigned once per edge, so a beat that follows an accepted one keeps
   // valid high without a glitch. The expectation is computed at the rising
   // edge that accepts the beat.
   task automatic send_beat(input logic [MODE_W-1:0] mode, input timing_type t);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.delay_len   <= t.dly_len;
      req_bus.attack_len  <= t.atk_len;
      req_bus.hold_len    <= t.hld_len;
      req_bus.decay_len   <= t.dcy_len;
      req_bus.release_len <= t.rel_len;
      req_bus.solid       <= t.solid;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_env.push_back(step_envelope(mode, t));
      beats_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: ready is randomized on the falling edge, unless a long
   // hold-off is running.
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);

   // The hold-off counts its own cycles so the sender can keep pushing beats
   // into the block while responses are blocked.
   always begin
      @(rx_hold_start);
      rx_hold = 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   // Every response beat is checked against the oldest outstanding
   // expectation, one field at a time.
   always @(posedge clock) begin
      env_result_type exp_r;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_env.size() == 0) begin
            report_error($sformatf("response with nothing expected: level %0d phase %0d",
                                   rsp_bus.level, rsp_bus.phase));
         end else begin
            exp_r = expected_env.pop_front();
            if (rsp_bus.level !== exp_r.level)
               report_error($sformatf("level got %0d, expected %0d",
                                      rsp_bus.level, exp_r.level));
            if (rsp_bus.phase !== exp_r.phase)
               report_error($sformatf("phase got %0d, expected %0d",
                                      rsp_bus.phase, exp_r.phase));
            if (rsp_bus.note_queued !== exp_r.note_queued)
               report_error($sformatf("note_queued got %0b, expected %0b",
                                      rsp_bus.note_queued, exp_r.note_queued));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Hand-picked sequence through every phase and each corner the block
   // has to get right: beats that must be ignored in idle, the unused mode,
   // queued notes where the latest one wins, zero-length phases, a note in
   // sustain that forces a release, a release of zero length, the slowest
   // release, and a note armed out of release keeping its level.
   task automatic test_directed_cases();
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_NOTE_OFF, ZERO_TIMING);
      send_beat(MODE_UNUSED, make_timing('1, '1, '1, '1, '1, 1'b1));

      // Short pulsed note; two notes queued while it runs.
      send_beat(MODE_NOTE_ON, make_timing(1, 2, 1, 2, 2, 1'b0));
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_NOTE_ON, make_timing('1, '1, '1, '1, '1, 1'b1));
      send_beat(MODE_NOTE_ON, make_timing(0, 0, 0, 0, 0, 1'b1));
      // Attack, hold, decay; the end of decay arms the all-zero solid note,
      // which goes straight through attack into sustain.
      repeat (7) send_beat(MODE_TICK, ZERO_TIMING);

      // Note in sustain: queued and release starts. Zero release length
      // drops to zero in one tick and the queued note is armed.
      send_beat(MODE_NOTE_ON, make_timing(0, 1, 0, 0, 0, 1'b1));
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_NOTE_OFF, ZERO_TIMING);
      send_beat(MODE_TICK, ZERO_TIMING);

      // Full level, then the slowest release (one step per tick), then a
      // new note out of release that keeps the level through its delay.
      send_beat(MODE_NOTE_ON, make_timing(0, 1, 0, 0, '1, 1'b1));
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_NOTE_OFF, ZERO_TIMING);
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_NOTE_ON, make_timing(2, '1, 0, '1, 3, 1'b0));
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_NOTE_OFF, ZERO_TIMING);
      send_beat(MODE_TICK, ZERO_TIMING);
      send_beat(MODE_UNUSED, random_fields());
   endtask

   // Random notes: most runs are a note followed by a burst of ticks with
   // the odd extra note or note-off mixed in; the rest are single beats of
   // any mode with arbitrary payload.
   task automatic test_random_envelopes(input int count, input int s_pct, input int r_pct);
      int target;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      target = beats_sent + count;
      while (beats_sent < target) begin
         if ($urandom_range(0, 3) == 0) begin
            send_beat(MODE_W'($urandom_range(0, 3)), random_fields());
         end else begin
            send_beat(MODE_NOTE_ON, random_timing());
            repeat ($urandom_range(1, 30)) begin
               case ($urandom_range(0, 19))
                  0:       send_beat(MODE_NOTE_ON, random_timing());
                  1, 2:    send_beat(MODE_NOTE_OFF, random_fields());
                  default: send_beat(MODE_TICK, random_fields());
               endcase
            end
            // Often let the note go and ride the release out.
            if ($urandom_range(0, 1) == 0) begin
               send_beat(MODE_NOTE_OFF, random_fields());
               repeat ($urandom_range(1, 12)) send_beat(MODE_TICK, random_fields());
            end
         end
      end
   endtask

   // Responses are blocked for a long stretch while the sender never idles,
   // so the block has to stall its request side.
   task automatic test_input_backpressure();
      send_idle_pct = 0;
      -> rx_hold_start;
      send_beat(MODE_NOTE_ON, make_timing(1, 4, 2, 4, 3, 1'b0));
      repeat (40) send_beat(MODE_TICK, random_fields());
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_TICK;
      req_bus.delay_len   = '0;
      req_bus.attack_len  = '0;
      req_bus.hold_len    = '0;
      req_bus.decay_len   = '0;
      req_bus.release_len = '0;
      req_bus.solid       = 1'b0;
      rsp_bus.ready       = 1'b0;
      send_idle_pct       = 37;
      recv_idle_pct       = 63;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_envelopes(420, 37, 63);
      test_input_backpressure();
      test_random_envelopes(420, 63, 37);
      test_random_envelopes(420, 0, 0);

      // Drop valid before the next rising edge so the last beat is not
      // taken twice, then let every response come back.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_env.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
